### design/indexed_binary_heap_queue_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed binary heap queue
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef INDEXED_BINARY_HEAP_QUEUE_DEFINES_SVH
`define INDEXED_BINARY_HEAP_QUEUE_DEFINES_SVH

// same-cycle implication
`define IBHQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IBHQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/ibhq_pkg.sv
// ----------------------------------------------------------------------------
// ibhq_pkg
// Field widths, operation, status and mark codes, sequencer states.
// ----------------------------------------------------------------------------
package ibhq_pkg;

   localparam int ID_W          = 10;
   localparam int FUNC_W        = 3;
   localparam int STATUS_W      = 3;
   localparam int MARK_W        = 2;
   localparam int FILL_W        = 11;
   localparam int IN_PRIO_W     = 32;
   localparam int ID_SPACE      = 1024;
   localparam int CAPACITY_DEF  = 1024;
   localparam int PRIO_BITS_DEF = 32;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_UPDATE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_RESET  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd4;

   localparam logic [MARK_W-1:0] MARK_WHITE = 2'd0;
   localparam logic [MARK_W-1:0] MARK_GRAY  = 2'd1;
   localparam logic [MARK_W-1:0] MARK_BLACK = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ECHK,
      S_UP,
      S_UPCMP,
      S_POPTOP,
      S_TAKE,
      S_LAST,
      S_DN,
      S_DNL,
      S_DNR,
      S_DNDEC,
      S_DONE
   } state_type;

endpackage

### design/ibhq_ifs.sv
// ----------------------------------------------------------------------------
// ibhq channel interfaces
// Request, response and control-register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface ibhq_req_if import ibhq_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [FUNC_W-1:0]           func;
   logic [ID_W-1:0]             element_id;
   logic signed [IN_PRIO_W-1:0] priority_value;
   modport source (output valid, func, element_id, priority_value, input ready);
   modport sink   (input valid, func, element_id, priority_value, output ready);
endinterface

interface ibhq_rsp_if import ibhq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     popped_id;
   logic [MARK_W-1:0]   element_mark;
   logic [FILL_W-1:0]   fill_count;
   modport source (output valid, status, popped_id, element_mark, fill_count, input ready);
   modport sink   (input valid, status, popped_id, element_mark, fill_count, output ready);
endinterface

interface ibhq_csr_if ();
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### design/ibhq_ram.sv
// ----------------------------------------------------------------------------
// ibhq_ram
// Generic one-write one-read RAM, registered read data.
// ----------------------------------------------------------------------------
module ibhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/indexed_binary_heap_queue.sv
// ----------------------------------------------------------------------------
// indexed_binary_heap_queue
// Indexed binary heap priority queue over element ids, min or max policy.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req_ch   in   valid/ready    func, element_id, priority_value
//  rsp_ch   out  valid/ready    status, popped_id, element_mark, fill_count
//  csr_ch   in   valid/ready    data = order_policy (0 min first, 1 max first)
//
//  One transaction at a time. Insert/update climb toward the root while the
//  entry strictly beats its parent. Pop/remove move the last entry to the
//  root and sink it, each level comparing the left and then the right child
//  (two heap reads a level on the single heap read port); remove adds its
//  forced climb first.
//  Reset and the reset operation sweep the whole element RAM; no request is
//  taken meanwhile. A held response stalls only the next finish.
// ----------------------------------------------------------------------------
`include "indexed_binary_heap_queue_defines.svh"

module indexed_binary_heap_queue import ibhq_pkg::*; #(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int PRIO_BITS = PRIO_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   ibhq_req_if.sink   req_ch,
   ibhq_rsp_if.source rsp_ch,
   ibhq_csr_if.sink   csr_ch
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int EW     = 1 + SLOT_W + MARK_W;  // {valid, slot, mark}
   localparam int HW     = ID_W + PRIO_BITS;     // {id, priority}
   localparam int LW     = SLOT_W + 2;           // child index width

   // winner test: a comes out strictly before b
   function automatic logic beats(input logic pol,
                                  input logic signed [PRIO_BITS-1:0] a,
                                  input logic signed [PRIO_BITS-1:0] b);
      return pol ? (a > b) : (a < b);
   endfunction

   state_type                    state_ff, state_in;
   logic                         order_ff;
   logic [FUNC_W-1:0]            func_ff, func_in;
   logic [ID_W-1:0]              id_ff, id_in;
   logic signed [PRIO_BITS-1:0]  key_ff, key_in;
   logic [SLOT_W-1:0]            pos_ff, pos_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [ID_W-1:0]              clr_ff, clr_in;
   logic                         clr_rsp_ff, clr_rsp_in;
   logic [ID_W-1:0]              top_ff, top_in;
   logic [HW-1:0]                mv_ff, mv_in;      // entry being sunk
   logic [HW-1:0]                bent_ff, bent_in;  // best entry so far
   logic [SLOT_W-1:0]            best_ff, best_in;
   logic [STATUS_W-1:0]          res_st_ff, res_st_in;
   logic [ID_W-1:0]              res_pop_ff, res_pop_in;
   logic [MARK_W-1:0]            res_mark_ff, res_mark_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]          rsp_st_ff, rsp_st_in;
   logic [ID_W-1:0]              rsp_pop_ff, rsp_pop_in;
   logic [MARK_W-1:0]            rsp_mark_ff, rsp_mark_in;
   logic [FILL_W-1:0]            rsp_fill_ff, rsp_fill_in;

   // RAM ports
   logic              heap_we;
   logic [SLOT_W-1:0] heap_wa, heap_ra;
   logic [HW-1:0]     heap_wd, heap_rd;
   logic              elem_we;
   logic [ID_W-1:0]   elem_wa, elem_ra;
   logic [EW-1:0]     elem_wd, elem_rd;

   logic                        id_ok;
   logic [ID_W-1:0]             rd_id;
   logic signed [PRIO_BITS-1:0] rd_key, bent_key;
   logic [LW-1:0]               lw, rw, cnt_w;
   logic [SLOT_W-1:0]           parent;
   logic [CNT_W-1:0]            cnt_dec;
   logic                        rsp_free;

   ibhq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap_ram (
      .clock(clock), .wr_en(heap_we), .wr_addr(heap_wa), .wr_data(heap_wd),
      .rd_addr(heap_ra), .rd_data(heap_rd)
   );

   ibhq_ram #(.WIDTH(EW), .DEPTH(ID_SPACE)) u_elem_ram (
      .clock(clock), .wr_en(elem_we), .wr_addr(elem_wa), .wr_data(elem_wd),
      .rd_addr(elem_ra), .rd_data(elem_rd)
   );

   assign rd_id    = heap_rd[HW-1 -: ID_W];
   assign rd_key   = $signed(heap_rd[PRIO_BITS-1:0]);
   assign bent_key = $signed(bent_ff[PRIO_BITS-1:0]);
   assign lw       = {1'b0, pos_ff, 1'b1};
   assign rw       = lw + LW'(1);
   assign cnt_w    = LW'(count_ff);
   assign parent   = SLOT_W'((pos_ff - SLOT_W'(1)) >> 1);
   assign cnt_dec  = count_ff - CNT_W'(1);
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign id_ok    = 32'(req_ch.element_id) < CAPACITY;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_st_ff;
   assign rsp_ch.popped_id    = rsp_pop_ff;
   assign rsp_ch.element_mark = rsp_mark_ff;
   assign rsp_ch.fill_count   = rsp_fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         order_ff     <= 1'b0;
         count_ff     <= '0;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            order_ff <= csr_ch.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      id_ff       <= id_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      top_ff      <= top_in;
      mv_ff       <= mv_in;
      bent_ff     <= bent_in;
      best_ff     <= best_in;
      res_st_ff   <= res_st_in;
      res_pop_ff  <= res_pop_in;
      res_mark_ff <= res_mark_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_pop_ff  <= rsp_pop_in;
      rsp_mark_ff <= rsp_mark_in;
      rsp_fill_ff <= rsp_fill_in;
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      id_in        = id_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      clr_rsp_in   = clr_rsp_ff;
      top_in       = top_ff;
      mv_in        = mv_ff;
      bent_in      = bent_ff;
      best_in      = best_ff;
      res_st_in    = res_st_ff;
      res_pop_in   = res_pop_ff;
      res_mark_in  = res_mark_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_st_in    = rsp_st_ff;
      rsp_pop_in   = rsp_pop_ff;
      rsp_mark_in  = rsp_mark_ff;
      rsp_fill_in  = rsp_fill_ff;
      heap_we      = 1'b0;
      heap_wa      = pos_ff;
      heap_wd      = {id_ff, key_ff};
      heap_ra      = '0;
      elem_we      = 1'b0;
      elem_wa      = id_ff;
      elem_wd      = {1'b1, pos_ff, MARK_GRAY};
      elem_ra      = req_ch.element_id;

      unique case (state_ff)
         S_CLEAR: begin
            // every element invalid and white
            elem_we = 1'b1;
            elem_wa = clr_ff;
            elem_wd = {1'b0, SLOT_W'(0), MARK_WHITE};
            clr_in  = clr_ff + ID_W'(1);
            if (clr_ff == ID_W'(ID_SPACE - 1)) begin
               count_in = '0;
               state_in = clr_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               func_in     = req_ch.func;
               id_in       = req_ch.element_id;
               key_in      = PRIO_BITS'(req_ch.priority_value);
               res_st_in   = ST_OK;
               res_pop_in  = '0;
               res_mark_in = MARK_WHITE;
               priority case (req_ch.func)
                  FUNC_INSERT, FUNC_UPDATE, FUNC_REMOVE: begin
                     if (!id_ok) begin
                        res_st_in = ST_NOT_QUEUED;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_ECHK;
                     end
                  end
                  FUNC_POP: begin
                     if (count_ff == '0) begin
                        res_st_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        heap_ra  = '0;
                        state_in = S_POPTOP;
                     end
                  end
                  FUNC_RESET: begin
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_ECHK: begin
            res_mark_in = elem_rd[MARK_W-1:0];
            priority case (func_ff)
               FUNC_INSERT: begin
                  if (elem_rd[EW-1]) begin
                     res_st_in = ST_QUEUED;
                     state_in  = S_DONE;
                  end else if (count_ff >= CNT_W'(CAPACITY)) begin
                     res_st_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     res_mark_in = MARK_GRAY;
                     pos_in      = SLOT_W'(count_ff);
                     count_in    = count_ff + CNT_W'(1);
                     state_in    = S_UP;
                  end
               end
               default: begin
                  if (!elem_rd[EW-1]) begin
                     res_st_in = ST_NOT_QUEUED;
                     state_in  = S_DONE;
                  end else begin
                     pos_in   = elem_rd[MARK_W +: SLOT_W];
                     state_in = S_UP;
                  end
               end
            endcase
         end
         S_UP: begin
            if (pos_ff == '0) begin
               if (func_ff == FUNC_REMOVE) begin
                  top_in   = id_ff;
                  state_in = S_TAKE;
               end else begin
                  heap_we  = 1'b1;
                  elem_we  = 1'b1;
                  state_in = S_DONE;
               end
            end else begin
               heap_ra  = parent;
               state_in = S_UPCMP;
            end
         end
         S_UPCMP: begin
            // remove climbs unconditionally, others on a strict win
            if (func_ff == FUNC_REMOVE || beats(order_ff, key_ff, rd_key)) begin
               heap_we  = 1'b1;
               heap_wd  = heap_rd;
               elem_we  = 1'b1;
               elem_wa  = rd_id;
               pos_in   = parent;
               state_in = S_UP;
            end else begin
               heap_we  = 1'b1;
               elem_we  = 1'b1;
               state_in = S_DONE;
            end
         end
         S_POPTOP: begin
            top_in   = rd_id;
            state_in = S_TAKE;
         end
         S_TAKE: begin
            elem_we  = 1'b1;
            elem_wa  = top_ff;
            elem_wd  = {1'b0, SLOT_W'(0),
                        (func_ff == FUNC_REMOVE) ? MARK_WHITE : MARK_BLACK};
            res_mark_in = (func_ff == FUNC_REMOVE) ? MARK_WHITE : MARK_BLACK;
            res_pop_in  = (func_ff == FUNC_POP) ? top_ff : '0;
            count_in    = cnt_dec;
            if (cnt_dec == '0) begin
               state_in = S_DONE;
            end else begin
               heap_ra  = SLOT_W'(cnt_dec);
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            mv_in    = heap_rd;
            pos_in   = '0;
            state_in = S_DN;
         end
         S_DN: begin
            best_in = pos_ff;
            bent_in = mv_ff;
            if (lw < cnt_w) begin
               heap_ra  = SLOT_W'(lw);
               state_in = S_DNL;
            end else begin
               heap_we  = 1'b1;
               heap_wd  = mv_ff;
               elem_we  = 1'b1;
               elem_wa  = mv_ff[HW-1 -: ID_W];
               state_in = S_DONE;
            end
         end
         S_DNL: begin
            // sinking swaps on ties too
            if (beats(order_ff, rd_key, bent_key) || rd_key == bent_key) begin
               best_in = SLOT_W'(lw);
               bent_in = heap_rd;
            end
            if (rw < cnt_w) begin
               heap_ra  = SLOT_W'(rw);
               state_in = S_DNR;
            end else begin
               state_in = S_DNDEC;
            end
         end
         S_DNR: begin
            if (beats(order_ff, rd_key, bent_key) || rd_key == bent_key) begin
               best_in = SLOT_W'(rw);
               bent_in = heap_rd;
            end
            state_in = S_DNDEC;
         end
         S_DNDEC: begin
            heap_we = 1'b1;
            elem_we = 1'b1;
            if (best_ff == pos_ff) begin
               heap_wd  = mv_ff;
               elem_wa  = mv_ff[HW-1 -: ID_W];
               state_in = S_DONE;
            end else begin
               heap_wd  = bent_ff;
               elem_wa  = bent_ff[HW-1 -: ID_W];
               pos_in   = best_ff;
               state_in = S_DN;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = clr_rsp_ff ? ST_OK : res_st_ff;
               rsp_pop_in   = clr_rsp_ff ? '0 : res_pop_ff;
               rsp_mark_in  = clr_rsp_ff ? MARK_WHITE : res_mark_ff;
               rsp_fill_in  = FILL_W'(count_ff);
               clr_rsp_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   `IBHQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY), "fill count above capacity")
   `IBHQ_ASSERT_NEXT(a_count_hold, clock, reset, state_ff != S_ECHK && state_ff != S_TAKE && state_ff != S_CLEAR, $stable(count_ff), "fill count moved outside an update state")
   `IBHQ_ASSERT_NEXT(a_rsp_issue, clock, reset, state_ff == S_DONE && rsp_free, rsp_valid_ff, "finished transaction not presented")
   `IBHQ_ASSERT_NOW(a_no_accept_busy, clock, reset, state_ff != S_IDLE, !(req_ch.valid && req_ch.ready), "request taken while busy")

endmodule
